>>> rtl/core/kas_pkg.sv
// Shared types and constants for the connection keepalive supervisor.
// No dependencies; every other file in rtl/core imports this package.
package kas_pkg;

	// Millisecond interval limits: 65535 s * 1000 fits in 26 bits.
	localparam int unsigned LIMIT_W = 26;
	localparam logic [LIMIT_W-1:0] MS_PER_SECOND = LIMIT_W'(1000);

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_SUBS  = 2'd2;

	localparam logic [LIMIT_W-1:0] KEEPALIVE_LIMIT_RST = LIMIT_W'(60000);
	localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST     = LIMIT_W'(10000);

	typedef logic [LIMIT_W-1:0] limit_t;

	// Received packet kinds; codes 6 and 7 behave like "other".
	localparam logic [2:0] PKT_CONNACK  = 3'd0;
	localparam logic [2:0] PKT_SUBACK   = 3'd1;
	localparam logic [2:0] PKT_PUBLISH  = 3'd2;
	localparam logic [2:0] PKT_PINGREQ  = 3'd3;
	localparam logic [2:0] PKT_PINGRESP = 3'd4;
	localparam logic [2:0] PKT_OTHER    = 3'd5;

	typedef enum logic [1:0] {
		TMR_NONE    = 2'd0,
		TMR_PING    = 2'd1,
		TMR_CLOSE   = 2'd2,
		TMR_CONNECT = 2'd3
	} timer_action_t;

	typedef enum logic [2:0] {
		PA_NONE      = 3'd0,
		PA_SUBSCRIBE = 3'd1,
		PA_PINGRESP  = 3'd2,
		PA_DELIVER   = 3'd3,
		PA_REFUSED   = 3'd4
	} packet_action_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        socket_up;
		logic        pkt_valid;
		logic [2:0]  pkt_kind;
		logic [7:0]  ack_code;
	} in_item_t;

	typedef struct packed {
		timer_action_t  timer_action;
		packet_action_t packet_action;
		logic           is_connected;
		logic           is_online;
		logic           ping_pending;
		logic           step_ok;
	} out_item_t;

	// Configuration as seen by the step logic.
	typedef struct packed {
		limit_t keepalive_limit;
		limit_t retry_limit;
		logic   has_subs;
	} cfg_t;

endpackage

>>> rtl/core/connection_keepalive_supervisor.sv
// Top level of the client connection keepalive supervisor.
// Depends on kas_pkg, kas_cfg and kas_step.
//
// Usage:
//   Each input transfer on item (item_valid / item_stall) carries the
//   current ms time, socket status and an optional received packet.
//   Every input transfer yields exactly one result transfer on result
//   (result_valid / result_stall) with the timer action, packet action
//   and the connection flags after that item.
//   An item passes the input register and then the result register
//   before its result transfer. Throughput: one item per cycle while
//   the receiver does not stall; the state update is a single 32-bit
//   subtract/compare pass between the input register and the result
//   register, so the following item sees the new state in the next
//   cycle.
//   When the receiver stalls, the result register holds its transfer
//   and the input register keeps its item; item_stall rises only when
//   both are full. An item in the input register does not touch the
//   state until it moves into the result register.
//   Reset clears the flags and activity times and loads the register
//   defaults (keepalive 60 s, retry 10 s, no subscriptions).
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
//   the next edge; intervals are stored already scaled to milliseconds.
module connection_keepalive_supervisor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  kas_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output kas_pkg::out_item_t            result,
	input  logic                          cfg_we,
	input  logic [kas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kas_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_s2;
	logic      valid_s2;
	out_item_t step_result;
	logic      advance;
	logic      accept;

	// Move the input register forward when the result slot is free or drains.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	kas_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// State commits only when the item leaves the input register.
	kas_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cfg     (cfg),
		.item    (item_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && result_stall);
		end
	end

	// Payload registers: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
		if (advance)
			result_s2 <= step_result;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

>>> rtl/core/kas_cfg.sv
// Configuration registers; intervals are held pre-scaled to milliseconds.
// Depends on kas_pkg.
module kas_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kas_pkg::CFG_DATA_W-1:0] cfg_data,
	output kas_pkg::cfg_t                 cfg
);
	import kas_pkg::*;

	limit_t keepalive_limit_q;
	limit_t retry_limit_q;
	logic   has_subs_q;
	limit_t wr_limit;

	// Scale seconds to ms once, at write time.
	assign wr_limit = LIMIT_W'(LIMIT_W'(cfg_data) * MS_PER_SECOND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_limit_q <= KEEPALIVE_LIMIT_RST;
			retry_limit_q     <= RETRY_LIMIT_RST;
			has_subs_q        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEPALIVE: keepalive_limit_q <= wr_limit;
				REG_RETRY:     retry_limit_q     <= wr_limit;
				REG_HAS_SUBS:  has_subs_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = '{keepalive_limit: keepalive_limit_q,
		retry_limit: retry_limit_q, has_subs: has_subs_q};

endmodule

>>> rtl/core/kas_step.sv
// Connection state registers and the per-item update logic.
// Depends on kas_pkg.
module kas_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  kas_pkg::cfg_t     cfg,
	input  kas_pkg::in_item_t item,
	output kas_pkg::out_item_t result
);
	import kas_pkg::*;

	logic        connected_q, online_q, ping_q;
	logic [31:0] last_in_q, last_out_q;

	logic        connected_d, online_d, ping_d;
	logic [31:0] last_in_d, last_out_d;
	logic [31:0] diff_in, diff_out;
	logic        ka_expired, retry_expired, closed;
	timer_action_t  tmr;
	packet_action_t pa;
	logic        ok;

	assign diff_in       = item.now_ms - last_in_q;
	assign diff_out      = item.now_ms - last_out_q;
	assign ka_expired    = (diff_in > 32'(cfg.keepalive_limit)) ||
		(diff_out > 32'(cfg.keepalive_limit));
	assign retry_expired = diff_out > 32'(cfg.retry_limit);

	always_comb begin
		connected_d = connected_q;
		online_d    = online_q;
		ping_d      = ping_q;
		last_in_d   = last_in_q;
		last_out_d  = last_out_q;
		tmr         = TMR_NONE;
		pa          = PA_NONE;
		ok          = 1'b1;
		closed      = 1'b0;
		if (connected_q) begin
			if (ka_expired) begin
				if (ping_q) begin
					// second expiry with a ping still out: drop the link
					connected_d = 1'b0;
					online_d    = 1'b0;
					tmr         = TMR_CLOSE;
					ok          = 1'b0;
					closed      = 1'b1;
				end else begin
					tmr        = TMR_PING;
					last_in_d  = item.now_ms;
					last_out_d = item.now_ms;
					ping_d     = 1'b1;
				end
			end
			if (!closed && item.pkt_valid) begin
				last_in_d = item.now_ms;
				case (item.pkt_kind)
					PKT_CONNACK: begin
						if (item.ack_code == 8'd0) begin
							if (cfg.has_subs)
								pa = PA_SUBSCRIBE;
						end else begin
							connected_d = 1'b0;
							online_d    = 1'b0;
							pa          = PA_REFUSED;
							ok          = 1'b0;
						end
					end
					PKT_SUBACK: begin
						online_d   = 1'b1;
						last_out_d = item.now_ms;
					end
					PKT_PUBLISH: pa = PA_DELIVER;
					PKT_PINGREQ: begin
						pa         = PA_PINGRESP;
						last_out_d = item.now_ms;
					end
					PKT_PINGRESP: ping_d = 1'b0;
					default: ;
				endcase
			end
		end else if (item.socket_up && !online_q && retry_expired) begin
			tmr         = TMR_CONNECT;
			last_in_d   = item.now_ms;
			last_out_d  = item.now_ms;
			connected_d = 1'b1;
			ping_d      = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			online_q    <= 1'b0;
			ping_q      <= 1'b0;
			last_in_q   <= '0;
			last_out_q  <= '0;
		end else if (step_en) begin
			connected_q <= connected_d;
			online_q    <= online_d;
			ping_q      <= ping_d;
			last_in_q   <= last_in_d;
			last_out_q  <= last_out_d;
		end
	end

	assign result = '{timer_action: tmr, packet_action: pa,
		is_connected: connected_d, is_online: online_d,
		ping_pending: ping_d, step_ok: ok};

endmodule

>>> rtl/core/kas_chk.sv
// Port-level checker for the keepalive supervisor, bound to the top level.
// Depends on kas_pkg and connection_keepalive_supervisor.
module kas_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input kas_pkg::out_item_t result
);
	import kas_pkg::*;

	// Hold a stalled result.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// A closing step always leaves the link down.
	a_close_down: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.step_ok |-> !result.is_connected && !result.is_online)
		else $error("step closed but link still flagged up");

	// A fresh connect starts clean and handles no packet.
	a_connect: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.timer_action == TMR_CONNECT |->
		result.is_connected && !result.ping_pending && !result.is_online &&
		result.packet_action == PA_NONE)
		else $error("connect step left inconsistent flags");

	// A timeout close drops any packet in the same item.
	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.timer_action == TMR_CLOSE |->
		result.packet_action == PA_NONE && !result.step_ok)
		else $error("timeout close with packet action");

endmodule

bind connection_keepalive_supervisor kas_chk u_kas_chk (.*);
